/* sv/b64lw_pkg.sv */
package b64lw_pkg;

  localparam int unsigned LINE_LEN_W = 10;
  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [7:0] CH_EQ = 8'h3D;  // '='
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // One accepted byte, classified: up to four characters to send in order.
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      cnt_m1;  // number of characters minus one
    logic            last;    // message ends with this byte
  } item_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      c = 8'h2B;  // '+'
    end else begin
      c = 8'h2F;  // '/'
    end
    return c;
  endfunction

endpackage

/* sv/b64lw_front.sv */
module b64lw_front import b64lw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       q_full,
  output logic       q_push,
  output item_t      q_item
);

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] carry_r, carry_nxt;
  logic [7:0] b;

  assign b         = in_tdata;
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    q_item        = '0;
    q_item.last   = in_tlast;
    phase_nxt     = phase_r;
    carry_nxt     = carry_r;
    case (phase_r)
      2'd1: begin
        q_item.chars[0] = b64_char({carry_r[1:0], b[7:4]});
        q_item.chars[1] = b64_char({b[3:0], 2'b00});
        q_item.chars[2] = CH_EQ;
        q_item.cnt_m1   = in_tlast ? 2'd2 : 2'd0;
        carry_nxt       = b[3:0];
        phase_nxt       = 2'd2;
      end
      2'd2: begin
        q_item.chars[0] = b64_char({carry_r[3:0], b[7:6]});
        q_item.chars[1] = b64_char(b[5:0]);
        q_item.cnt_m1   = 2'd1;
        carry_nxt       = '0;
        phase_nxt       = 2'd0;
      end
      default: begin  // phase 0; phase 3 never occurs and acts as 0
        q_item.chars[0] = b64_char(b[7:2]);
        q_item.chars[1] = b64_char({b[1:0], 4'b0000});
        q_item.chars[2] = CH_EQ;
        q_item.chars[3] = CH_EQ;
        q_item.cnt_m1   = in_tlast ? 2'd3 : 2'd0;
        carry_nxt       = {2'b00, b[1:0]};
        phase_nxt       = 2'd1;
      end
    endcase
    if (in_tlast) begin
      phase_nxt = '0;
      carry_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      carry_r <= '0;
    end else if (q_push) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

endmodule

/* sv/b64lw_fifo.sv */
module b64lw_fifo import b64lw_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  not_empty,
  output logic  full
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  item_t              mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == CNT_W'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* sv/b64lw_back.sv */
module b64lw_back import b64lw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [LINE_LEN_W-1:0] line_length,
  input  item_t                 head,
  input  logic                  head_valid,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,
  output logic                  out_tlast
);

  typedef enum logic [1:0] {S_CHR, S_CR, S_LF} state_t;

  state_t                st_r, st_nxt;
  logic [1:0]            idx_r, idx_nxt;
  logic [LINE_LEN_W-1:0] line_cnt_r, line_cnt_nxt;
  logic                  valid_r, valid_nxt;
  logic [7:0]            data_r, data_nxt;
  logic                  last_r, last_nxt;

  logic                  ld, go, is_end, wrap;
  logic [LINE_LEN_W-1:0] limit, cnt_inc;

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

  assign ld      = !valid_r || out_tready;
  assign go      = ld && head_valid;
  assign is_end  = (idx_r == head.cnt_m1);
  // a one-character line behaves as two
  assign limit   = (line_length == LINE_LEN_W'(1)) ? LINE_LEN_W'(2) : line_length;
  assign cnt_inc = line_cnt_r + 1'b1;
  assign wrap    = (line_length != '0) && (cnt_inc >= limit);

  always_comb begin
    st_nxt       = st_r;
    idx_nxt      = idx_r;
    line_cnt_nxt = line_cnt_r;
    valid_nxt    = ld ? head_valid : valid_r;
    data_nxt     = data_r;
    last_nxt     = last_r;
    pop          = 1'b0;
    if (go) begin
      case (st_r)
        S_CHR: begin
          data_nxt = head.chars[idx_r];
          last_nxt = is_end && !wrap;
          if (wrap) begin
            line_cnt_nxt = '0;
            st_nxt       = S_CR;
          end else begin
            if (line_length != '0) begin
              line_cnt_nxt = cnt_inc;
            end
            if (is_end) begin
              pop     = 1'b1;
              idx_nxt = '0;
              if (head.last) begin
                line_cnt_nxt = '0;
              end
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
        end
        S_CR: begin
          data_nxt = CH_CR;
          last_nxt = 1'b0;
          st_nxt   = S_LF;
        end
        S_LF: begin
          data_nxt = CH_LF;
          last_nxt = is_end;
          st_nxt   = S_CHR;
          if (is_end) begin
            pop     = 1'b1;
            idx_nxt = '0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        default: begin
          st_nxt = S_CHR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_CHR;
      idx_r      <= '0;
      line_cnt_r <= '0;
      valid_r    <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      idx_r      <= idx_nxt;
      line_cnt_r <= line_cnt_nxt;
      valid_r    <= valid_nxt;
    end
    data_r <= data_nxt;
    last_r <= last_nxt;
  end

endmodule

/* sv/base64_line_wrap_encoder_top.sv */
// Streaming base64 encoder with optional CR LF line wrapping.
// Input channel (in_*): one raw byte per request, in_tlast marks the last
// byte of a message. Output channel (out_*): one ASCII character per
// request; out_tlast is set on the final character caused by each byte.
// cfg_we/cfg_wdata load the line length (0 = no wrapping); write it only
// while the block is idle.
// The front end converts each byte into up to four characters in the
// cycle it is accepted and parks them in a two-entry queue, written at
// the accepting edge; the back end handles line counting and CR LF
// insertion and loads each character into the output register.
// Throughput is set by the output stage, which sends one character per
// cycle while out_tready is high; a byte yields 1 to 8 characters (about
// 1.33 on average plus CR LF), so bytes go in slower than characters out.
// Reset (rst_n low, synchronous) clears group phase, carry bits, line
// count, queue and line length. When out_tready is low the output register
// holds its character; the queue keeps taking bytes until it fills, then
// in_tready drops.
module base64_line_wrap_encoder_top import b64lw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [LINE_LEN_W-1:0] cfg_wdata,   // line_length
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,    // [7:0] data_byte
  input  logic                  in_tlast,    // last_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,   // [7:0] out_char
  output logic                  out_tlast    // last_char
);

  logic [LINE_LEN_W-1:0] line_length_r;

  logic  q_push, q_pop, q_full, q_not_empty;
  item_t q_in, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r <= '0;
    end else if (cfg_we) begin
      line_length_r <= cfg_wdata;
    end
  end

  // Front: accept and classify bytes into character groups
  b64lw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in)
  );

  // Decoupling queue
  b64lw_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // Back: line wrapping and output register
  b64lw_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .line_length (line_length_r),
    .head        (q_head),
    .head_valid  (q_not_empty),
    .pop         (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  // CR is never the end of a byte's characters
  a_cr_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata == CH_CR) |-> !out_tlast)
    else $error("CR flagged as last character");

  // a delivered CR is always followed at once by LF
  a_cr_then_lf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tdata == CH_CR) |=>
      (out_tvalid && out_tdata == CH_LF))
    else $error("CR not followed by LF");

  // queue pops only what it holds
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_not_empty)
    else $error("queue popped while empty");

endmodule

/* sim/base64_line_wrap_encoder_top_tb.sv */
module base64_line_wrap_encoder_top_tb;
  import b64lw_pkg::*;

  localparam int RAND_ITEMS  = 460;  // random bytes after the directed table
  localparam int HOLD_CYCLES = 200;  // long receiver hold-off, fills the byte queue
  localparam int DRAIN_WAIT  = 20;   // idle cycles after the last expected char

  // Standard alphabet, entry 0 is 'A'.
  localparam logic [0:63][7:0] ALPHA =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;

  // One directed row: a line length write or one byte request. n_chars > 0
  // means the characters are typed in here (first char in the highest used
  // byte), otherwise the encoder model supplies them.
  typedef struct packed {
    row_kind_t   kind;
    logic [9:0]  value;
    logic        last;
    logic [3:0]  n_chars;
    logic [63:0] chars;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_char_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [LINE_LEN_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;   // [7:0] data_byte
  logic                  in_tlast;   // last_byte
  logic                  out_tvalid;
  logic                  out_tready;
  logic [7:0]            out_tdata;  // [7:0] out_char
  logic                  out_tlast;  // last_char

  // Encoder model state.
  logic [9:0] enc_line_len;
  logic [9:0] enc_line_cnt;
  logic [1:0] enc_phase;
  logic [3:0] enc_carry;
  logic [7:0] step_chars[$];      // chars produced by the byte just taken

  out_char_t  pending_chars[$];   // characters still owed by the block
  out_char_t  want;
  dir_row_t   dir_rows[$];
  int         err_count = 0;
  int         burst_left = 0;
  bit         hold_off_req = 1'b0;

  base64_line_wrap_encoder_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Encoder model
  // ---------------------------------------------------------------------

  // Append one character; with wrapping on, CR LF closes a full line.
  // A length of 1 behaves as 2 so that padding never needs more than 8 chars.
  function automatic void emit_char(input logic [7:0] c);
    logic [9:0] limit;
    step_chars.push_back(c);
    if (enc_line_len != 10'd0) begin
      limit = (enc_line_len == 10'd1) ? 10'd2 : enc_line_len;
      enc_line_cnt = enc_line_cnt + 10'd1;
      // also covers a count left above a freshly lowered length
      if (enc_line_cnt >= limit) begin
        step_chars.push_back(CH_CR);
        step_chars.push_back(CH_LF);
        enc_line_cnt = 10'd0;
      end
    end
  endfunction

  function automatic void encode_byte(input logic [7:0] d, input logic is_last);
    case (enc_phase)
      2'd1: begin
        emit_char(ALPHA[{enc_carry[1:0], d[7:4]}]);
        enc_carry = d[3:0];
        enc_phase = 2'd2;
        if (is_last) begin
          emit_char(ALPHA[{enc_carry, 2'b00}]);
          emit_char(CH_EQ);
        end
      end
      2'd2: begin
        emit_char(ALPHA[{enc_carry, d[7:6]}]);
        emit_char(ALPHA[d[5:0]]);
        enc_carry = 4'd0;
        enc_phase = 2'd0;
      end
      default: begin
        // phase 3 never occurs and falls in here with phase 0
        emit_char(ALPHA[d[7:2]]);
        enc_carry = {2'b00, d[1:0]};
        enc_phase = 2'd1;
        if (is_last) begin
          emit_char(ALPHA[{d[1:0], 4'b0000}]);
          emit_char(CH_EQ);
          emit_char(CH_EQ);
        end
      end
    endcase
    // end of message: next byte starts a new group and a new line
    if (is_last) begin
      enc_phase    = 2'd0;
      enc_carry    = 4'd0;
      enc_line_cnt = 10'd0;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic dir_row_t byte_row(input logic [7:0] d, input logic is_last,
                                        input logic [3:0] n, input logic [63:0] c);
    dir_row_t r;
    r.kind    = ROW_BYTE;
    r.value   = {2'b00, d};
    r.last    = is_last;
    r.n_chars = n;
    r.chars   = c;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [9:0] v);
    dir_row_t r;
    r.kind    = ROW_CFG;
    r.value   = v;
    r.last    = 1'b0;
    r.n_chars = 4'd0;
    r.chars   = 64'd0;
    return r;
  endfunction

  // Drop valid and wait until every owed character has come out.
  task automatic wait_idle();
    if (in_tvalid) in_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  task automatic write_line_len(input logic [9:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    enc_line_len = v;
  endtask

  // Offer one byte, hold it until the request is taken, then log what it
  // owes. Bursts of back-to-back requests alternate with random gaps.
  task automatic send_byte(input logic [7:0] d, input logic is_last,
                           input int n_typed, input logic [63:0] typed);
    out_char_t r;
    int        gap;
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= is_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);

    step_chars.delete();
    encode_byte(d, is_last);
    if (n_typed > 0) begin
      for (int i = 0; i < n_typed; i++) begin
        r.ch   = typed[8*(n_typed-1-i) +: 8];
        r.last = (i == n_typed - 1);
        pending_chars.push_back(r);
      end
    end else begin
      foreach (step_chars[i]) begin
        r.ch   = step_chars[i];
        r.last = (i == step_chars.size() - 1);
        pending_chars.push_back(r);
      end
    end

    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 8);
      gap = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver: stalls on its own pattern, plus one long hold-off on request
  // ---------------------------------------------------------------------
  initial begin
    int mode;
    int seg_len;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode    = $urandom_range(0, 3);
        seg_len = $urandom_range(8, 64);
        repeat (seg_len) begin
          case (mode)
            0:       out_tready <= 1'b1;                        // no stalls
            1:       out_tready <= 1'($urandom_range(0, 1));    // coin flip
            2:       out_tready <= ($urandom_range(0, 3) == 0); // mostly stalled
            default: out_tready <= ~out_tready;                 // alternates high and low
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output check: each char request against the oldest owed character
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected char: got %h last %b", out_tdata, out_tlast);
      end else begin
        want = pending_chars.pop_front();
        if (out_tdata !== want.ch || out_tlast !== want.last) begin
          err_count++;
          if (err_count <= 10)
            $display("char mismatch: expected %h last %b, got %h last %b",
                     want.ch, want.last, out_tdata, out_tlast);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int         rand_sent;
    int         phase_cnt;
    int         n_msgs;
    int         msg_len;
    logic [9:0] len_sel;
    logic [7:0] d;

    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;

    enc_line_len = 10'd0;
    enc_line_cnt = 10'd0;
    enc_phase    = 2'd0;
    enc_carry    = 4'd0;

    // Directed table. Typed rows run with wrapping off, straight from reset.
    dir_rows.push_back(byte_row(8'h00, 1'b1, 4'd4, 64'("AA==")));  // one-byte msg, zeros
    dir_rows.push_back(byte_row(8'hFF, 1'b1, 4'd4, 64'("/w==")));  // one-byte msg, ones
    dir_rows.push_back(byte_row(8'h4D, 1'b0, 4'd1, 64'("T")));     // full group
    dir_rows.push_back(byte_row(8'h61, 1'b0, 4'd1, 64'("W")));
    dir_rows.push_back(byte_row(8'h6E, 1'b1, 4'd2, 64'("Fu")));
    dir_rows.push_back(byte_row(8'hFF, 1'b0, 4'd1, 64'("/")));     // two-byte msg
    dir_rows.push_back(byte_row(8'hFF, 1'b1, 4'd3, 64'("/8=")));
    dir_rows.push_back(byte_row(8'hFB, 1'b0, 4'd1, 64'("+")));     // all-plus group
    dir_rows.push_back(byte_row(8'hEF, 1'b0, 4'd1, 64'("+")));
    dir_rows.push_back(byte_row(8'hBE, 1'b1, 4'd2, 64'("++")));
    // one-char lines act as two: single-byte message gives the 8-char worst case
    dir_rows.push_back(cfg_row(10'd1));
    dir_rows.push_back(byte_row(8'h00, 1'b1, 4'd0, 64'd0));
    dir_rows.push_back(byte_row(8'h12, 1'b0, 4'd0, 64'd0));
    dir_rows.push_back(byte_row(8'h34, 1'b0, 4'd0, 64'd0));
    dir_rows.push_back(byte_row(8'h56, 1'b1, 4'd0, 64'd0));
    // fill four chars of a five-char line, then lower the length mid-message
    dir_rows.push_back(cfg_row(10'd5));
    dir_rows.push_back(byte_row(8'h10, 1'b0, 4'd0, 64'd0));
    dir_rows.push_back(byte_row(8'h20, 1'b0, 4'd0, 64'd0));
    dir_rows.push_back(byte_row(8'h30, 1'b0, 4'd0, 64'd0));
    dir_rows.push_back(cfg_row(10'd2));
    dir_rows.push_back(byte_row(8'h40, 1'b0, 4'd0, 64'd0));
    dir_rows.push_back(byte_row(8'hC0, 1'b1, 4'd0, 64'd0));
    dir_rows.push_back(cfg_row(10'd1023));                  // widest line
    dir_rows.push_back(byte_row(8'hA5, 1'b0, 4'd0, 64'd0));
    dir_rows.push_back(byte_row(8'h5A, 1'b1, 4'd0, 64'd0));
    dir_rows.push_back(cfg_row(10'd0));                     // wrapping off again
    dir_rows.push_back(byte_row(8'h7F, 1'b1, 4'd0, 64'd0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_line_len(dir_rows[i].value);
      end else begin
        send_byte(dir_rows[i].value[7:0], dir_rows[i].last,
                  int'(dir_rows[i].n_chars), dir_rows[i].chars);
      end
    end

    // Random phases: new line length while idle, then a few messages.
    // Some phases stop mid-message so the next length lands inside one.
    rand_sent = 0;
    phase_cnt = 0;
    while (rand_sent < RAND_ITEMS) begin
      case ($urandom_range(0, 7))
        0:       len_sel = 10'd0;
        1:       len_sel = 10'd1;
        2:       len_sel = 10'd2;
        3:       len_sel = 10'd3;
        4:       len_sel = 10'd1023;
        5:       len_sel = 10'd76;
        6:       len_sel = 10'($urandom_range(4, 20));
        default: len_sel = 10'($urandom_range(0, 1023));
      endcase
      write_line_len(len_sel);

      // one long receiver hold-off while the sender keeps offering bytes
      if (phase_cnt == 3) hold_off_req = 1'b1;

      n_msgs = $urandom_range(1, 6);
      repeat (n_msgs) begin
        msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                              : $urandom_range(1, 8);
        for (int k = 0; k < msg_len; k++) begin
          d = 8'($urandom_range(0, 255));
          send_byte(d, (k == msg_len - 1), 0, 64'd0);
          rand_sent++;
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        msg_len = $urandom_range(1, 5);
        repeat (msg_len) begin
          d = 8'($urandom_range(0, 255));
          send_byte(d, 1'b0, 0, 64'd0);
          rand_sent++;
        end
      end
      phase_cnt++;
    end

    // close any open message, then drain
    send_byte(8'($urandom_range(0, 255)), 1'b1, 0, 64'd0);
    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_count == 0 && pending_chars.size() == 0) begin
      $display("base64_line_wrap_encoder_top_tb: clean");
    end else begin
      $display("base64_line_wrap_encoder_top_tb: errors");
    end
    $finish;
  end

  // Watchdog: the slowest honest run (about 480 bytes x 8 chars at a
  // mostly-stalled receiver, sender gaps, one hold-off) ends well inside it.
  initial begin
    #4_000_000;
    $display("base64_line_wrap_encoder_top_tb: errors");
    $finish;
  end

endmodule
